// ===== hw/rtl/cdfp_pkg.sv =====
package cdfp_pkg;

    localparam int unsigned FrameLen  = 15;
    localparam int unsigned BodyLen   = FrameLen - 1;
    localparam int unsigned ModeCount = 8;

    localparam logic [7:0] StartByte     = 8'hAA;
    localparam logic [7:0] DeviceDefault = 8'h1A;
    localparam logic [3:0] PhaseMask     = 4'h0F;
    localparam logic [2:0] PhaseLast     = 3'd3;
    localparam logic [2:0] PhaseNone     = 3'd4;
    localparam logic [3:0] ModeNone      = 4'd8;

    localparam logic [3:0] PosHunt  = 4'd0;
    localparam logic [3:0] PosFinal = 4'd15;

    localparam logic [7:0] ModeCodes [ModeCount] = '{
        8'h35, 8'h22, 8'h2F, 8'h50, 8'h52, 8'h54, 8'h56, 8'h58
    };

    typedef logic [7:0] t_byte;
    typedef t_byte t_body [BodyLen];

    localparam logic STATUS_ACCEPTED     = 1'b0;
    localparam logic STATUS_WRONG_DEVICE = 1'b1;

    typedef struct packed {
        logic        frame_status;
        logic        checksum_ok;
        logic [15:0] battery_voltage;
        logic [15:0] panel_voltage;
        logic [15:0] panel_current;
        logic [7:0]  controller_temperature;
        logic [2:0]  charge_phase;
        logic [3:0]  charge_mode;
        logic [7:0]  controller_status;
        logic [7:0]  flags_first;
        logic [7:0]  flags_second;
        logic [7:0]  flags_third;
    } t_result;

endpackage

// ===== hw/rtl/cdfp_decode.sv =====
module cdfp_decode (
    input  cdfp_pkg::t_body   i_body,
    input  cdfp_pkg::t_byte   i_check_byte,
    input  cdfp_pkg::t_byte   i_running_xor,
    input  cdfp_pkg::t_byte   i_expected_device,
    input  logic [2:0]        i_last_phase,
    input  logic [3:0]        i_last_mode,
    output cdfp_pkg::t_result o_result,
    output logic [2:0]        o_next_phase,
    output logic [3:0]        o_next_mode
);
    import cdfp_pkg::*;

    logic       accepted;
    logic [3:0] phase_code;

    // The first matching mode code wins; an unknown code keeps the last mode.
    always_comb begin
        accepted     = (i_body[0] == i_expected_device);
        phase_code   = i_body[12][3:0] & PhaseMask;
        o_next_phase = i_last_phase;
        o_next_mode  = i_last_mode;
        if (accepted) begin
            if (phase_code <= {1'b0, PhaseLast}) begin
                o_next_phase = phase_code[2:0];
            end
            for (int k = ModeCount - 1; k >= 0; k--) begin
                if (i_body[11] == ModeCodes[k]) begin
                    o_next_mode = 4'(k);
                end
            end
        end
    end

    always_comb begin
        o_result              = '0;
        o_result.frame_status = accepted ? STATUS_ACCEPTED : STATUS_WRONG_DEVICE;
        o_result.checksum_ok  = (i_running_xor == i_check_byte);
        if (accepted) begin
            o_result.battery_voltage        = {i_body[2], i_body[1]};
            o_result.panel_voltage          = {i_body[4], i_body[3]};
            o_result.panel_current          = {i_body[6], i_body[5]};
            o_result.controller_temperature = i_body[10];
            o_result.controller_status      = i_body[13];
            o_result.flags_first            = i_body[7];
            o_result.flags_second           = i_body[8];
            o_result.flags_third            = i_body[9];
        end
        o_result.charge_phase = o_next_phase;
        o_result.charge_mode  = o_next_mode;
    end

endmodule

// ===== hw/rtl/charger_display_frame_parser.sv =====
// Frame parser for a charger display link.
// The receive channel (i_rx_valid, o_rx_stall, i_rx_byte) carries one serial
// byte per transaction. Bytes are dropped until the start byte 0xAA, and the
// next fifteen bytes form one frame.
// The result channel (o_res_valid, i_res_stall and the field ports) carries
// one transaction for each completed frame.
// A byte is registered in the input register when it is accepted; the result
// register loads when the byte that completes a frame advances, which waits
// while a valid result is stalled. One byte can be accepted in every cycle
// unless a completed frame waits on a stalled result; throughput is set by
// the single input register, which frees once its byte has been handled.
// The expected device id is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset drops any byte or result in flight, returns the parser to hunting for
// the start byte, restores the expected id and marks phase and mode as unseen.
// While the receiver stalls, a waiting result holds its value; bytes that
// produce no result keep flowing, and the byte that completes a frame waits
// in the input register, which then stalls the receive channel.
module charger_display_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic       o_frame_status,
    output logic       o_checksum_ok,
    output logic [15:0] o_battery_voltage,
    output logic [15:0] o_panel_voltage,
    output logic [15:0] o_panel_current,
    output logic [7:0] o_controller_temperature,
    output logic [2:0] o_charge_phase,
    output logic [3:0] o_charge_mode,
    output logic [7:0] o_controller_status,
    output logic [7:0] o_flags_first,
    output logic [7:0] o_flags_second,
    output logic [7:0] o_flags_third
);
    import cdfp_pkg::*;

    t_byte      r_expected_device;
    logic       r_in_valid;
    t_byte      r_in_byte;
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    t_body      r_body;
    t_byte      r_xor;
    t_byte      n_xor;
    logic [2:0] r_last_phase;
    logic [3:0] r_last_mode;
    logic       r_res_valid;
    t_result    r_result;

    t_result    dec_result;
    logic [2:0] dec_phase;
    logic [3:0] dec_mode;
    logic       emit;
    logic       advance;
    logic       rx_take;

    cdfp_decode u_decode (
        .i_body            (r_body),
        .i_check_byte      (r_in_byte),
        .i_running_xor     (r_xor),
        .i_expected_device (r_expected_device),
        .i_last_phase      (r_last_phase),
        .i_last_mode       (r_last_mode),
        .o_result          (dec_result),
        .o_next_phase      (dec_phase),
        .o_next_mode       (dec_mode)
    );

    always_comb begin
        emit    = r_in_valid && (r_pos == PosFinal);
        advance = r_in_valid && (!emit || !r_res_valid || !i_res_stall);
        rx_take = i_rx_valid && !o_rx_stall;
        n_pos   = r_pos;
        n_xor   = r_xor;
        if (r_pos == PosHunt) begin
            if (r_in_byte == StartByte) begin
                n_pos = 4'd1;
                n_xor = '0;
            end
        end else if (r_pos == PosFinal) begin
            n_pos = PosHunt;
        end else begin
            n_pos = r_pos + 4'd1;
            n_xor = r_xor ^ r_in_byte;
        end
    end

    assign o_rx_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_device <= DeviceDefault;
            r_in_valid        <= 1'b0;
            r_pos             <= PosHunt;
            r_xor             <= '0;
            r_last_phase      <= PhaseNone;
            r_last_mode       <= ModeNone;
            r_res_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expected_device <= i_cfg_wdata;
            end
            if (advance || !r_in_valid) begin
                r_in_valid <= rx_take;
            end
            if (advance) begin
                r_pos <= n_pos;
                r_xor <= n_xor;
                if (emit) begin
                    r_last_phase <= dec_phase;
                    r_last_mode  <= dec_mode;
                end
            end
            if (advance && emit) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && (r_pos != PosHunt) && (r_pos != PosFinal)) begin
            for (int k = 0; k < BodyLen - 1; k++) begin
                r_body[k] <= r_body[k + 1];
            end
            r_body[BodyLen - 1] <= r_in_byte;
        end
        if (advance && emit) begin
            r_result <= dec_result;
        end
    end

    assign o_res_valid              = r_res_valid;
    assign o_frame_status           = r_result.frame_status;
    assign o_checksum_ok            = r_result.checksum_ok;
    assign o_battery_voltage        = r_result.battery_voltage;
    assign o_panel_voltage          = r_result.panel_voltage;
    assign o_panel_current          = r_result.panel_current;
    assign o_controller_temperature = r_result.controller_temperature;
    assign o_charge_phase           = r_result.charge_phase;
    assign o_charge_mode            = r_result.charge_mode;
    assign o_controller_status      = r_result.controller_status;
    assign o_flags_first            = r_result.flags_first;
    assign o_flags_second           = r_result.flags_second;
    assign o_flags_third            = r_result.flags_third;

endmodule
